// ===== hw/rtl/pve_pkg.sv =====
// Shared constants and types of the pose velocity estimator.
`timescale 1ns / 1ps

package pve_pkg;

   // Fixed-point format of positions, angles and rates.
   localparam int FRAC_BITS   = 16;
   localparam int CONST_SHIFT = 32 - FRAC_BITS;

   // Field widths.
   localparam int POS_W     = 32;
   localparam int HEAD_W    = 20;
   localparam int RATE_W    = 32;
   localparam int SRATE_W   = 14;
   localparam int KEEP_W    = 16;

   // Datapath widths: exact differences, multiplier operands and products.
   localparam int DIFF_W    = POS_W + 1;
   localparam int MUL_A_W   = DIFF_W + 1;
   localparam int MUL_B_W   = KEEP_W + 2;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;

   // The filter weight is Q0.16, so the accumulated result drops 16 bits.
   localparam int FILT_SHIFT = 16;
   localparam logic [KEEP_W:0] KEEP_ONE = (KEEP_W + 1)'(1 << FILT_SHIFT);

   // 2*pi and pi in Q4.32, rounded to nearest at the chosen fraction width.
   localparam logic [35:0] TWO_PI_Q32 = 36'h6487ED511;
   localparam logic [35:0] PI_Q32     = 36'h3243F6A89;
   localparam logic signed [DIFF_W-1:0] TWO_PI =
      DIFF_W'((TWO_PI_Q32 + (36'd1 << (CONST_SHIFT - 1))) >> CONST_SHIFT);
   localparam logic signed [DIFF_W-1:0] PI_VAL =
      DIFF_W'((PI_Q32 + (36'd1 << (CONST_SHIFT - 1))) >> CONST_SHIFT);
   localparam logic signed [DIFF_W-1:0] NEG_PI = -PI_VAL;

   // Register map of the configuration port.
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_KEEP = CSR_IDX_W'(1);
   localparam logic [SRATE_W-1:0] SAMPLE_RATE_RESET = SRATE_W'(100);
   localparam logic [KEEP_W-1:0]  FILTER_KEEP_RESET = KEEP_W'(45875);

   // What the accumulator does with the product that reaches it.
   typedef struct packed {
      logic load;    // start afresh from the product plus one half
      logic accum;   // add the product to the running sum
   } mac_ctl_type;

endpackage

// ===== hw/rtl/pve_mac.sv =====
// Shared multiplier with saturating tap and rounding accumulator.
`timescale 1ns / 1ps

module pve_mac import pve_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [MUL_A_W-1:0]  op_a,
   input  logic signed [MUL_B_W-1:0]  op_b,
   input  mac_ctl_type                ctl,
   output logic signed [PROD_W-1:0]   acc,
   output logic signed [RATE_W-1:0]   prod_sat
);

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (FILT_SHIFT - 1));
   localparam logic signed [PROD_W-1:0] SAT_MAX    = PROD_W'((64'd1 << (RATE_W - 1)) - 64'd1);
   localparam logic signed [PROD_W-1:0] SAT_MIN    = -(SAT_MAX + PROD_W'(1));

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] acc_ff;
   mac_ctl_type              ctl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      if (ctl_ff.load) begin
         acc_ff <= prod_ff + ROUND_HALF;
      end else if (ctl_ff.accum) begin
         acc_ff <= acc_ff + prod_ff;
      end
   end

   // Clamp of the registered product to the signed rate range.
   always_comb begin
      if (prod_ff > SAT_MAX) begin
         prod_sat = SAT_MAX[RATE_W-1:0];
      end else if (prod_ff < SAT_MIN) begin
         prod_sat = SAT_MIN[RATE_W-1:0];
      end else begin
         prod_sat = prod_ff[RATE_W-1:0];
      end
   end

   assign acc = acc_ff;

endmodule

// ===== hw/rtl/pose_velocity_estimator.sv =====
// Pose velocity estimator: filtered planar rates from a stream of pose samples.
//
// Each item on the req_ channel is one pose sample (x, y, heading). The block
// forms backward differences against the previous sample, wraps the heading
// difference towards [-pi, pi), scales each difference by the sample rate with
// saturation to 32 bits and passes it through a first-order low-pass filter.
// The three filtered rates leave as one item on the rsp_ channel.
// An item is taken in the idle state and then worked through eleven steps of the
// sequencer, which issues three operations per axis to the one shared
// multiplier, each axis overlapping the two-stage multiply and accumulate of
// the one before. A new item is taken only once the sequencer is back in
// idle after the final step.
// The result waits in an output register, so the next item is accepted and
// worked on while it is held; only the final step waits for the slot if the
// receiver has not yet taken the previous result.
// The csr_ port writes sample_rate (index 0) and filter_keep (index 1) and is
// ready whenever reset is low; it is meant to be written while the block is idle.
// Synchronous reset restores the register defaults and zeroes the stored pose
// and the filter state; no item is accepted during reset.
`timescale 1ns / 1ps

module pose_velocity_estimator import pve_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // Pose items; fields from bit 0: pos_x[31:0], pos_y[63:32], heading[83:64], zero pad.
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [87:0]          req_tdata,
   // Rate items; fields from bit 0: vel_x[31:0], vel_y[63:32], turn_rate[95:64].
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [95:0]          rsp_tdata,
   // Register writes.
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   localparam logic [1:0] CHAN_X    = 2'd0;
   localparam logic [1:0] CHAN_Y    = 2'd1;
   localparam logic [1:0] CHAN_H    = 2'd2;
   localparam logic [1:0] CHAN_DONE = 2'd3;
   localparam logic [1:0] PH_RATE   = 2'd0;
   localparam logic [1:0] PH_KEEP   = 2'd1;
   localparam logic [1:0] PH_RAW    = 2'd2;

   state_type state_ff;
   logic [1:0] chan_ff;
   logic [1:0] phase_ff;

   logic [SRATE_W-1:0] sample_rate_ff;
   logic [KEEP_W-1:0]  filter_keep_ff;

   logic signed [POS_W-1:0]  last_x_ff;
   logic signed [POS_W-1:0]  last_y_ff;
   logic signed [HEAD_W-1:0] last_h_ff;
   logic signed [RATE_W-1:0] smooth_x_ff;
   logic signed [RATE_W-1:0] smooth_y_ff;
   logic signed [RATE_W-1:0] smooth_h_ff;

   logic signed [DIFF_W-1:0] dx_ff;
   logic signed [DIFF_W-1:0] dy_ff;
   logic signed [DIFF_W-1:0] dh_ff;
   logic signed [DIFF_W-1:0] dh_in;
   logic signed [RATE_W-1:0] raw_ff;

   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;

   logic signed [POS_W-1:0]  in_x;
   logic signed [POS_W-1:0]  in_y;
   logic signed [HEAD_W-1:0] in_h;

   logic signed [MUL_A_W-1:0] mac_a;
   logic signed [MUL_B_W-1:0] mac_b;
   mac_ctl_type               mac_ctl;
   logic signed [PROD_W-1:0]  mac_acc;
   logic signed [RATE_W-1:0]  mac_sat;
   logic signed [RATE_W-1:0]  filt_res;
   logic signed [DIFF_W-1:0]  diff_sel;
   logic signed [RATE_W-1:0]  old_sel;

   logic accept;
   logic last_step;
   logic out_free;
   logic running;

   assign in_x = req_tdata[31:0];
   assign in_y = req_tdata[63:32];
   assign in_h = req_tdata[83:64];

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = !reset;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign running   = (state_ff == ST_RUN);
   assign last_step = running && (chan_ff == CHAN_DONE) && (phase_ff == PH_KEEP);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign filt_res  = mac_acc[FILT_SHIFT+RATE_W-1:FILT_SHIFT];

   // Operands for the current axis.
   always_comb begin
      case (chan_ff)
         CHAN_X: begin
            diff_sel = dx_ff;
            old_sel  = smooth_x_ff;
         end
         CHAN_Y: begin
            diff_sel = dy_ff;
            old_sel  = smooth_y_ff;
         end
         CHAN_H: begin
            diff_sel = dh_ff;
            old_sel  = smooth_h_ff;
         end
         default: begin
            diff_sel = '0;
            old_sel  = '0;
         end
      endcase
   end

   // Each axis issues scale, keep-weighted old output, then weighted raw rate.
   always_comb begin
      mac_a   = '0;
      mac_b   = '0;
      mac_ctl = '0;
      if (running && (chan_ff != CHAN_DONE)) begin
         case (phase_ff)
            PH_RATE: begin
               mac_a = MUL_A_W'(diff_sel);
               mac_b = $signed({(MUL_B_W - SRATE_W)'(0), sample_rate_ff});
            end
            PH_KEEP: begin
               mac_a = MUL_A_W'(old_sel);
               mac_b = $signed({(MUL_B_W - KEEP_W)'(0), filter_keep_ff});
               mac_ctl.load = 1'b1;
            end
            PH_RAW: begin
               mac_a = MUL_A_W'(raw_ff);
               mac_b = $signed({1'b0, KEEP_ONE - {1'b0, filter_keep_ff}});
               mac_ctl.accum = 1'b1;
            end
            default: begin
               mac_a = '0;
            end
         endcase
      end
   end

   // Heading wrap: one add or subtract of 2*pi per step.
   always_comb begin
      if (dh_ff < NEG_PI) begin
         dh_in = dh_ff + TWO_PI;
      end else if (dh_ff >= PI_VAL) begin
         dh_in = dh_ff - TWO_PI;
      end else begin
         dh_in = dh_ff;
      end
   end

   pve_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .op_a     (mac_a),
      .op_b     (mac_b),
      .ctl      (mac_ctl),
      .acc      (mac_acc),
      .prod_sat (mac_sat)
   );

   // Sequencer, configuration and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         chan_ff        <= CHAN_X;
         phase_ff       <= PH_RATE;
         rsp_valid_ff   <= 1'b0;
         sample_rate_ff <= SAMPLE_RATE_RESET;
         filter_keep_ff <= FILTER_KEEP_RESET;
         last_x_ff      <= '0;
         last_y_ff      <= '0;
         last_h_ff      <= '0;
         smooth_x_ff    <= '0;
         smooth_y_ff    <= '0;
         smooth_h_ff    <= '0;
      end else begin
         if (csr_valid) begin
            if (csr_index == CSR_SAMPLE_RATE) begin
               sample_rate_ff <= csr_data[SRATE_W-1:0];
            end else if (csr_index == CSR_FILTER_KEEP) begin
               filter_keep_ff <= csr_data[KEEP_W-1:0];
            end
         end

         // A new result fills the slot; otherwise a taken result empties it.
         if (last_step && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  last_x_ff <= in_x;
                  last_y_ff <= in_y;
                  last_h_ff <= in_h;
                  chan_ff   <= CHAN_X;
                  phase_ff  <= PH_RATE;
                  state_ff  <= ST_RUN;
               end
            end
            ST_RUN: begin
               // The filter result of the previous axis is ready in the keep phase.
               if (phase_ff == PH_KEEP) begin
                  case (chan_ff)
                     CHAN_Y:    smooth_x_ff <= filt_res;
                     CHAN_H:    smooth_y_ff <= filt_res;
                     CHAN_DONE: smooth_h_ff <= filt_res;
                     default:   smooth_x_ff <= smooth_x_ff;
                  endcase
               end
               if (last_step) begin
                  if (out_free) begin
                     state_ff <= ST_IDLE;
                  end
               end else if (phase_ff == PH_RAW) begin
                  phase_ff <= PH_RATE;
                  chan_ff  <= chan_ff + 2'd1;
               end else begin
                  phase_ff <= phase_ff + 2'd1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff <= DIFF_W'(in_x) - DIFF_W'(last_x_ff);
         dy_ff <= DIFF_W'(in_y) - DIFF_W'(last_y_ff);
         dh_ff <= DIFF_W'(in_h) - DIFF_W'(last_h_ff);
      end else if (running && (chan_ff == CHAN_X) && (phase_ff != PH_RAW)) begin
         dh_ff <= dh_in;
      end
      if (running && (phase_ff == PH_KEEP)) begin
         raw_ff <= mac_sat;
      end
      if (last_step && out_free) begin
         rsp_data_ff <= {filt_res, smooth_y_ff, smooth_x_ff};
      end
   end

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input accepted again while an item is being worked on");

   a_result_from_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(last_step))
      else $error("result raised outside the final step");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      running |-> (phase_ff != 2'd3) && ((chan_ff != CHAN_DONE) || (phase_ff != PH_RAW)))
      else $error("sequencer step out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (last_step && rsp_valid_ff && !rsp_tready) |=> running)
      else $error("sequencer left the final step while the result slot was full");
`endif

endmodule

// ===== tb/sv/pose_velocity_estimator_tb.sv =====
// Self-checking testbench of the pose velocity estimator, with its own rate predictor.
`timescale 1ns / 1ps

module pose_velocity_estimator_tb import pve_pkg::*; ();

   // Register indexes that lie outside the map; writes to them must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LOW = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_TOP = CSR_IDX_W'(255);

   // One turn and half a turn in Q16.16, rounded to nearest.
   localparam longint FULL_TURN = 411775;
   localparam longint HALF_TURN = 205887;
   localparam longint RATE_MAX  = 64'sd2147483647;
   localparam longint RATE_MIN  = -64'sd2147483648;

   // The limit leaves a wide margin over the slowest correct run.
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BLOCKS = 9;
   localparam int BLOCK_ITEMS = 150;

   // Expected rates, packed in the same order as rsp_tdata (vel_x in the lowest bits).
   typedef struct packed {
      logic [31:0] turn_rate;
      logic [31:0] vel_y;
      logic [31:0] vel_x;
   } rate_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   // Fields from bit 0: pos_x[31:0], pos_y[63:32], heading[83:64], zero pad.
   logic [87:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // Fields from bit 0: vel_x[31:0], vel_y[63:32], turn_rate[95:64].
   logic [95:0]          rsp_tdata;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_data = '0;

   // The predictor's copy of the registers and of the block's state, as after reset.
   logic [13:0]        rate_setting = 14'd100;
   logic [15:0]        keep_setting = 16'd45875;
   logic signed [31:0] last_x = '0;
   logic signed [31:0] last_y = '0;
   logic signed [31:0] last_heading = '0;
   logic signed [31:0] smooth_vx = '0;
   logic signed [31:0] smooth_vy = '0;
   logic signed [31:0] smooth_rate = '0;

   rate_item_type rate_queue[$];
   int         error_count = 0;
   int         cycle_count = 0;
   // 0: no idling, 1: occasional bursts, 2: frequent bursts; shared by both sides.
   int         idle_level = 0;

   pose_velocity_estimator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // A run that hangs anywhere ends here rather than running on.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Scaled differences saturate to the signed 32-bit range.
   function automatic logic signed [31:0] clamp_rate(input longint value);
      if (value > RATE_MAX) return 32'sh7FFF_FFFF;
      if (value < RATE_MIN) return 32'sh8000_0000;
      return 32'(value);
   endfunction

   // First-order low-pass with round half up; the arithmetic shift floors.
   function automatic logic signed [31:0] lowpass(input logic signed [31:0] old,
                                                   input logic signed [31:0] raw);
      longint acc;
      acc = longint'(keep_setting) * longint'(old)
          + (65536 - longint'(keep_setting)) * longint'(raw) + 32768;
      return 32'(acc >>> 16);
   endfunction

   // Works out the filtered rates that one pose sample causes and advances the state.
   function automatic rate_item_type estimate_rates(input logic [31:0] x,
                                                    input logic [31:0] y,
                                                    input logic [19:0] h);
      longint        dx;
      longint        dy;
      longint        dh;
      rate_item_type rates;
      dx = longint'($signed(x)) - longint'(last_x);
      dy = longint'($signed(y)) - longint'(last_y);
      dh = longint'($signed(h)) - longint'(last_heading);
      // The heading difference is pulled towards [-pi, pi) by at most two corrections,
      // so a jump of two and a half turns or more stays partly unwrapped.
      repeat (2) begin
         if (dh < -HALF_TURN) dh += FULL_TURN;
         else if (dh >= HALF_TURN) dh -= FULL_TURN;
      end
      smooth_vx   = lowpass(smooth_vx, clamp_rate(dx * longint'(rate_setting)));
      smooth_vy   = lowpass(smooth_vy, clamp_rate(dy * longint'(rate_setting)));
      smooth_rate = lowpass(smooth_rate, clamp_rate(dh * longint'(rate_setting)));
      last_x       = $signed(x);
      last_y       = $signed(y);
      last_heading = 32'($signed(h));
      rates.vel_x     = smooth_vx;
      rates.vel_y     = smooth_vy;
      rates.turn_rate = smooth_rate;
      return rates;
   endfunction

   // Offers one pose item, possibly after an idle burst, and records its expected rates
   // at the edge where it is taken. Valid is left high so that items can follow back to
   // back; whoever stops sending lowers it.
   task automatic send_pose(input logic [31:0] x, input logic [31:0] y, input logic [19:0] h);
      if (idle_level != 0 && $urandom_range(0, idle_level == 2 ? 2 : 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tdata  <= {4'b0000, h, y, x};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      rate_queue.push_back(estimate_rates(x, y, h));
   endtask

   // Stops sending and waits until every expected item has arrived.
   task automatic wait_for_rates();
      req_tvalid <= 1'b0;
      while (rate_queue.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Writes one register once the block has gone idle, and mirrors it in the predictor.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [15:0] value);
      wait_for_rates();
      csr_index <= index;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (index == CSR_SAMPLE_RATE) rate_setting = value[13:0];
      else if (index == CSR_FILTER_KEEP) keep_setting = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // The receiver stalls in bursts while idling is enabled and is otherwise always ready.
   initial begin
      forever begin
         @(posedge clock);
         if (idle_level != 0 && $urandom_range(0, idle_level == 2 ? 2 : 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted rate item is compared field by field with the oldest expectation.
   always @(posedge clock) begin : check_rates
      rate_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rate_queue.size() == 0) begin
            $display("%0t: rate item with nothing expected: %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = rate_queue.pop_front();
            if (rsp_tdata[31:0] !== want.vel_x) begin
               $display("%0t: vel_x expected %h, got %h", $time, want.vel_x, rsp_tdata[31:0]);
               error_count++;
            end
            if (rsp_tdata[63:32] !== want.vel_y) begin
               $display("%0t: vel_y expected %h, got %h", $time, want.vel_y,
                        rsp_tdata[63:32]);
               error_count++;
            end
            if (rsp_tdata[95:64] !== want.turn_rate) begin
               $display("%0t: turn_rate expected %h, got %h", $time, want.turn_rate,
                        rsp_tdata[95:64]);
               error_count++;
            end
         end
      end
   end

   // Gentle motion with the register values from reset.
   task automatic test_default_rates();
      send_pose(32'h0000_0000, 32'h0000_0000, 20'h00000);
      send_pose(32'h0001_0000, 32'hFFFF_0000, 20'h003E8);
      send_pose(32'h0002_0000, 32'hFFFE_0000, 20'h007D0);
   endtask

   // Full-scale position jumps, which saturate both ways, and every corner of the
   // heading wrap: exactly plus and minus pi, just beyond them, and jumps of more
   // than two turns made from the widest 20-bit patterns.
   task automatic test_position_extremes();
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 20'(411775));
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 20'(-411775));
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 20'(-205888));
      send_pose(32'h0000_0000, 32'hFFFF_FFFF, 20'(0));
      send_pose(32'hFFFF_FFFF, 32'h0000_0000, 20'(-205887));
      send_pose(32'h8000_0000, 32'h8000_0000, 20'(0));
      send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20'(-205888));
      send_pose(32'h0000_0001, 32'hFFFF_FFFE, 20'h7FFFF);
      send_pose(32'hFFFF_FFFF, 32'h0000_0001, 20'h80000);
      send_pose(32'h5555_5555, 32'hAAAA_AAAA, 20'h7FFFF);
   endtask

   // Both registers at their limits, a zero sample rate, the unused upper bits of the
   // sample rate, and writes to indexes outside the map.
   task automatic test_register_extremes();
      write_csr(CSR_SAMPLE_RATE, 16'h0000);
      send_pose(32'h0001_0000, 32'hFFFF_0000, 20'h10000);
      send_pose(32'h7FFF_FFFF, 32'h8000_0000, 20'h80000);
      write_csr(CSR_SAMPLE_RATE, 16'hFFFF);
      write_csr(CSR_FILTER_KEEP, 16'h0000);
      send_pose(32'h0000_0000, 32'h0000_0000, 20'h00000);
      send_pose(32'h0000_8000, 32'hFFFF_8000, 20'h08000);
      write_csr(CSR_SAMPLE_RATE, 16'd1);
      write_csr(CSR_FILTER_KEEP, 16'hFFFF);
      send_pose(32'h8000_0000, 32'h7FFF_FFFF, 20'h3FFFF);
      send_pose(32'h8000_0001, 32'h7FFF_FFFE, 20'hC0000);
      write_csr(CSR_SAMPLE_RATE, 16'd10000);
      write_csr(CSR_FILTER_KEEP, 16'hAAAA);
      send_pose(32'h0000_0100, 32'hFFFF_FF00, 20'h00100);
      send_pose(32'h1234_5678, 32'h8765_4321, 20'h5A5A5);
      write_csr(CSR_UNUSED_LOW, 16'hFFFF);
      write_csr(CSR_UNUSED_TOP, 16'h0000);
      send_pose(32'h0000_0000, 32'h0000_0000, 20'h00000);
      write_csr(CSR_SAMPLE_RATE, 16'd100);
      write_csr(CSR_FILTER_KEEP, 16'd45875);
   endtask

   // Blocks of random poses, each under a fresh register setting and idling level. Most
   // items follow a plausible trajectory; the rest are heading jumps, poses near the
   // edges of the position range, standstill and raw noise over every bit. Each new
   // setting makes the sender wait until all expected items have come. The last block
   // runs without idling.
   task automatic test_random_poses();
      int cur_x;
      int cur_y;
      int cur_h;
      int block;
      int n;
      cur_x = 0;
      cur_y = 0;
      cur_h = 0;
      for (block = 0; block < RANDOM_BLOCKS; block++) begin
         case ($urandom_range(0, 4))
            0: write_csr(CSR_SAMPLE_RATE, 16'd0);
            1: write_csr(CSR_SAMPLE_RATE, 16'd1);
            2: write_csr(CSR_SAMPLE_RATE, 16'd10000);
            3: write_csr(CSR_SAMPLE_RATE, 16'($urandom_range(1, 10000)));
            default: write_csr(CSR_SAMPLE_RATE, 16'($urandom()));
         endcase
         case ($urandom_range(0, 4))
            0: write_csr(CSR_FILTER_KEEP, 16'd0);
            1: write_csr(CSR_FILTER_KEEP, 16'hFFFF);
            2: write_csr(CSR_FILTER_KEEP, 16'd45875);
            default: write_csr(CSR_FILTER_KEEP, 16'($urandom()));
         endcase
         idle_level = (block == RANDOM_BLOCKS - 1) ? 0 : int'($urandom_range(0, 2));
         for (n = 0; n < BLOCK_ITEMS; n++) begin
            case ($urandom_range(0, 15))
               12: begin
                  cur_x = int'($urandom());
                  cur_y = int'($urandom());
                  cur_h = int'($signed(20'($urandom())));
               end
               13: cur_h = int'($urandom_range(0, 823550)) - 411775;
               14: begin
                  cur_x = ($urandom_range(0, 1) ? int'(32'h7FFF_0000) : int'(32'h8000_0000))
                        + int'($urandom_range(0, 65535));
                  cur_y = ($urandom_range(0, 1) ? int'(32'h7FFF_0000) : int'(32'h8000_0000))
                        + int'($urandom_range(0, 65535));
               end
               15: ;
               default: begin
                  cur_x += int'($urandom_range(0, 8000)) - 4000;
                  cur_y += int'($urandom_range(0, 8000)) - 4000;
                  cur_h += int'($urandom_range(0, 40000)) - 20000;
                  // Keep the heading in the usual half-open range around zero.
                  if (cur_h >= HALF_TURN) cur_h -= FULL_TURN;
                  else if (cur_h < -HALF_TURN) cur_h += FULL_TURN;
               end
            endcase
            send_pose(32'(cur_x), 32'(cur_y), 20'(cur_h));
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_default_rates();
      test_position_extremes();
      test_register_extremes();
      test_random_poses();
      wait_for_rates();
      // A short watch for stray items after the last expected one.
      repeat (30) @(posedge clock);
      if (error_count == 0 && rate_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
